// ===== rtl/lss_pkg.sv =====
// shared constants and types for the lifo stack with search
`default_nettype none
package lss_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 6;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_SEARCH  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

endpackage
`default_nettype wire

// ===== rtl/lss_req_if.sv =====
// request channel of the lifo stack: command and value
`default_nettype none
interface lss_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic signed [lss_pkg::DATA_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lss_rsp_if.sv =====
// result channel of the lifo stack: status, data, position and last marker
`default_nettype none
interface lss_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [lss_pkg::DATA_W-1:0]  data;
  logic [lss_pkg::POS_W-1:0]          position;
  logic                               last;

  modport source (output valid, output status, output data, output position, output last,
                  input ready);
  modport sink   (input valid, input status, input data, input position, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/lifo_stack_with_search.sv =====
// lifo stack of signed words with pop, push, top-down search and display
//
// req_i carries one request (cmd, value); rsp_o returns its results, both
// valid/ready. push and pop give one result, search gives one result with
// the one-based position of the first match from the top, display gives
// one result per held entry, top first, with last set on the bottom one.
// the entries sit in a single-port-read memory with a registered read.
// push: entry written at accept, result loaded in the emit state.
// pop: read issued at accept, result loaded from the read data when scanning.
// search and display: the scan reads one entry a cycle from the top while
// the output register can take a result; a search that hits stops at the
// match. a pop, search or display on an empty stack gets an empty status.
// a request is taken only when the previous one has finished its work; the
// output register lets a finished result wait while the next request is
// taken. when the receiver stalls the scan holds on the current entry and
// resumes once the output register drains.
// reset clears the entry count and the control state; the memory itself is
// not cleared since only entries below the count are ever read.
`default_nettype none
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  lss_req_if.sink       req_i,
  lss_rsp_if.source     rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = lss_pkg::DATA_W;
  localparam int unsigned PW = lss_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;
  lss_pkg::cmd_e    cmd_q, cmd_d;
  lss_pkg::status_e pend_q, pend_d;
  logic [DW-1:0]    key_q, key_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [PW-1:0]    pos_q, pos_d;

  logic                 out_valid_q, out_valid_d;
  lss_pkg::status_e     out_status_q, out_status_d;
  logic [DW-1:0]        out_data_q, out_data_d;
  logic [PW-1:0]        out_pos_q, out_pos_d;
  logic                 out_last_q, out_last_d;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] rd_addr;

  logic          accept, can_out, load, empty, full;
  logic [AW-1:0] top_addr;

  assign accept   = req_i.valid && req_i.ready;
  assign can_out  = !out_valid_q || rsp_o.ready;
  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(DEPTH));
  assign top_addr = AW'(count_q - CW'(1));

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.data     = out_data_q;
  assign rsp_o.position = out_pos_q;
  assign rsp_o.last     = out_last_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pend_d       = pend_q;
    key_d        = key_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    rd_addr      = idx_q;
    load         = 1'b0;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = lss_pkg::cmd_e'(req_i.cmd);
          key_d   = req_i.value;
          idx_d   = top_addr;
          pos_d   = PW'(1);
          rd_addr = top_addr;
          unique case (lss_pkg::cmd_e'(req_i.cmd))
            lss_pkg::CMD_PUSH: begin
              state_d = S_EMIT;
              if (full) begin
                pend_d = lss_pkg::ST_FULL;
              end else begin
                pend_d  = lss_pkg::ST_OK;
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            lss_pkg::CMD_POP: begin
              if (empty) begin
                pend_d  = lss_pkg::ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                mem_re  = 1'b1;
                count_d = count_q - CW'(1);
                state_d = S_SCAN;
              end
            end
            lss_pkg::CMD_SEARCH, lss_pkg::CMD_DISPLAY: begin
              if (empty) begin
                pend_d  = lss_pkg::ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                mem_re  = 1'b1;
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        if (can_out) begin
          load         = 1'b1;
          out_status_d = pend_q;
          out_data_d   = '0;
          out_pos_d    = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (can_out) begin
          rd_addr = idx_q - AW'(1);
          unique case (cmd_q)
            lss_pkg::CMD_PUSH, lss_pkg::CMD_POP: begin
              load         = 1'b1;
              out_status_d = lss_pkg::ST_OK;
              out_data_d   = rdata_q;
              out_pos_d    = '0;
              out_last_d   = 1'b1;
              state_d      = S_IDLE;
            end
            lss_pkg::CMD_SEARCH: begin
              if (rdata_q == key_q) begin
                load         = 1'b1;
                out_status_d = lss_pkg::ST_OK;
                out_data_d   = '0;
                out_pos_d    = pos_q;
                out_last_d   = 1'b1;
                state_d      = S_IDLE;
              end else if (idx_q == '0) begin
                load         = 1'b1;
                out_status_d = lss_pkg::ST_NOTFOUND;
                out_data_d   = '0;
                out_pos_d    = '0;
                out_last_d   = 1'b1;
                state_d      = S_IDLE;
              end else begin
                mem_re = 1'b1;
                idx_d  = idx_q - AW'(1);
                pos_d  = pos_q + PW'(1);
              end
            end
            lss_pkg::CMD_DISPLAY: begin
              load         = 1'b1;
              out_status_d = lss_pkg::ST_OK;
              out_data_d   = rdata_q;
              out_pos_d    = '0;
              out_last_d   = (idx_q == '0);
              if (idx_q == '0) begin
                state_d = S_IDLE;
              end else begin
                mem_re = 1'b1;
                idx_d  = idx_q - AW'(1);
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // entry store, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= req_i.value;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pend_q       <= pend_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_pos_q    <= out_pos_d;
    out_last_q   <= out_last_d;
  end

endmodule
`default_nettype wire

// ===== sim/lss_checker.sv =====
// checker for the lifo stack: watches both channels, predicts each result and compares
`default_nettype none
module lss_checker
  import lss_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  lss_req_if          req_i,
  lss_rsp_if          rsp_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic [POS_W-1:0]    position;
    logic                last;
  } result_t;

  result_t             expected_q[$];
  logic [DATA_W-1:0]   entries [DEPTH];
  int unsigned         held;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    held        = 0;
  end

  function automatic result_t make_result(status_e st, logic [DATA_W-1:0] word,
                                          logic [POS_W-1:0] pos, logic fin);
    result_t r;
    r.status   = st;
    r.data     = word;
    r.position = pos;
    r.last     = fin;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("status %0d data %h position %0d last %b",
                     r.status, r.data, r.position, r.last);
  endfunction

  task automatic log_fault(string msg);
    if (err_count_o < 10) $display("lss_checker: %s", msg);
    err_count_o++;
  endtask

  // works out the results of one request and updates the stack copy
  task automatic predict_results(cmd_e op, logic [DATA_W-1:0] key);
    int unsigned idx;
    bit          hit;
    case (op)
      CMD_PUSH: begin
        if (held >= DEPTH) begin
          expected_q.push_back(make_result(ST_FULL, '0, '0, 1'b1));
        end else begin
          entries[held] = key;
          held++;
          expected_q.push_back(make_result(ST_OK, '0, '0, 1'b1));
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          expected_q.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          held--;
          expected_q.push_back(make_result(ST_OK, entries[held], '0, 1'b1));
        end
      end
      CMD_SEARCH: begin
        if (held == 0) begin
          expected_q.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          hit = 1'b0;
          for (idx = 0; idx < held && !hit; idx++) begin
            if (entries[held - 1 - idx] == key) begin
              hit = 1'b1;
              expected_q.push_back(make_result(ST_OK, '0, POS_W'(idx + 1), 1'b1));
            end
          end
          if (!hit) expected_q.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
        end
      end
      default: begin
        if (held == 0) begin
          expected_q.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          for (idx = 0; idx < held; idx++) begin
            expected_q.push_back(make_result(ST_OK, entries[held - 1 - idx], '0,
                                             idx + 1 == held));
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      held = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = make_result(status_e'(rsp_i.status), rsp_i.data, rsp_i.position, rsp_i.last);
        if (expected_q.size() == 0) begin
          log_fault($sformatf("result with none expected: got %s", show(got)));
        end else begin
          want = expected_q.pop_front();
          if (got !== want)
            log_fault($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
        end
      end
      // a result never belongs to the request taken at the same edge
      if (req_i.valid && req_i.ready) predict_results(cmd_e'(req_i.cmd), req_i.value);
    end
    pending_o = expected_q.size();
  end

endmodule
`default_nettype wire

// ===== sim/tb_lifo_stack_with_search.sv =====
// testbench top for the lifo stack: clock, reset, request stimulus, result stalls and verdict
`default_nettype none
module tb_lifo_stack_with_search;
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned PHASE_ITEMS = 68;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned err_count;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_token = 0;
  int unsigned reqs_sent = 0;
  logic [DATA_W-1:0] pushed_q[$];

  lss_req_if req_if ();
  lss_rsp_if rsp_if ();

  lifo_stack_with_search dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lss_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever the token moves
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_token != hold_taken) begin
        hold_taken = hold_token;
        hold_left  = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return DATA_W'($urandom_range(7));
      1:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    if (pushed_q.size() != 0 && $urandom_range(99) < 70)
      return pushed_q[$urandom_range(pushed_q.size() - 1)];
    return pick_value();
  endfunction

  task automatic send_req(cmd_e op, logic [DATA_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= op;
    req_if.value <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    reqs_sent++;
    if (op == CMD_PUSH) begin
      pushed_q.push_back(word);
      if (pushed_q.size() > 40) void'(pushed_q.pop_front());
    end
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_sequence();
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(9);
    case (pick)
      5, 6: begin
        // fill towards full, then look at the whole stack
        repeat ($urandom_range(20, 34)) send_req(CMD_PUSH, pick_value());
        send_req(CMD_DISPLAY, $urandom);
        send_req(CMD_SEARCH, pick_key());
      end
      7, 8: repeat ($urandom_range(8, 34)) send_req(CMD_POP, $urandom);
      9:    repeat ($urandom_range(1, 4)) send_req(cmd_e'($urandom_range(3)), $urandom);
      default: begin
        repeat ($urandom_range(4, 10)) begin
          r = $urandom_range(99);
          if (r < 40)      send_req(CMD_PUSH, pick_value());
          else if (r < 65) send_req(CMD_POP, $urandom);
          else if (r < 90) send_req(CMD_SEARCH, pick_key());
          else             send_req(CMD_DISPLAY, $urandom);
        end
      end
    endcase
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.cmd   <= CMD_PUSH;
    req_if.value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack cases, extremes, duplicates and first match from the top
    send_req(CMD_POP, 32'h0);
    send_req(CMD_SEARCH, 32'h0);
    send_req(CMD_DISPLAY, 32'hffff_ffff);
    send_req(CMD_PUSH, 32'h8000_0000);
    send_req(CMD_PUSH, 32'h7fff_ffff);
    send_req(CMD_PUSH, 32'h0);
    send_req(CMD_PUSH, 32'hffff_ffff);
    send_req(CMD_DISPLAY, 32'h0);
    send_req(CMD_SEARCH, 32'h7fff_ffff);
    send_req(CMD_SEARCH, 32'h8000_0000);
    send_req(CMD_SEARCH, 32'h0000_0005);
    send_req(CMD_PUSH, 32'h7fff_ffff);
    send_req(CMD_SEARCH, 32'h7fff_ffff);
    send_req(CMD_POP, 32'h0);
    send_req(CMD_POP, 32'h0);
    send_req(CMD_SEARCH, 32'hffff_ffff);
    send_req(CMD_DISPLAY, 32'h0);
    repeat (4) send_req(CMD_POP, 32'hffff_ffff);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 69; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 69; end
        default: begin idle_pct = 35; stall_pct <= 35; end
      endcase
      if (ph == 0) begin
        // long hold-off on results while pushes keep being offered
        hold_token <= hold_token + 1;
        repeat (40) send_req(CMD_PUSH, pick_value());
        wait_drain();
      end
      while (reqs_sent < (ph + 1) * PHASE_ITEMS) run_sequence();
      wait_drain();
    end

    repeat (DEPTH + 8) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lss_pkg.sv
rtl/lss_req_if.sv
rtl/lss_rsp_if.sv
rtl/lifo_stack_with_search.sv
sim/lss_checker.sv
sim/tb_lifo_stack_with_search.sv
